[hw/rtl/pnvd_pkg.sv]
// ----------------------------------------------------------------------------
// pnvd_pkg
// shared constants and helpers for the voss dice pink noise block
// ----------------------------------------------------------------------------
package pnvd_pkg;

  // number of dice, a power of two so the die index is a plain bit slice
  localparam int NUM_DICE   = 16;
  localparam int DIE_IDX_W  = $clog2(NUM_DICE);

  localparam int WORD_W     = 32;
  localparam int DIE_SHIFT  = 13;
  localparam int DIE_W      = WORD_W - DIE_SHIFT;
  localparam int SUM_W      = DIE_W + DIE_IDX_W;
  localparam int SAMPLE_W   = 24;
  localparam int TZ_W       = $clog2(WORD_W) + 1;

  // offset that centers the sample, 2^22 in q1.22
  localparam logic [SAMPLE_W-1:0] HALF_SCALE = SAMPLE_W'(1) << (SAMPLE_W - 2);

  // trailing-zero count of the select word, reduced to a die index;
  // an all-zero word picks die 0
  function automatic logic [DIE_IDX_W-1:0] die_index(input logic [WORD_W-1:0] w);
    logic [TZ_W-1:0] n;
    n = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        n = TZ_W'(i);
      end
    end
    return n[DIE_IDX_W-1:0];
  endfunction

endpackage

[hw/rtl/pnvd_ram.sv]
// ----------------------------------------------------------------------------
// pnvd_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module pnvd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // read-first: a read at the write address returns the old word
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

[hw/rtl/pink_noise_voss_dice.sv]
// ----------------------------------------------------------------------------
// pink_noise_voss_dice
// voss dice pink noise: one die refreshed and one sample made per transfer
// ----------------------------------------------------------------------------
// path: the dice ram read is launched at the input transfer edge, the update
//   and sum are done while the item waits in stage 1, and the sample is
//   registered when stage 1 moves on into a free output register
// throughput: one transfer per cycle unless output stalls, set by the single
//   read-modify-write of one die per item on a one-read, one-write ram
// reset: synchronous, active low; clears the running sum and the per-die
//   valid bits, so unwritten dice read as zero and no ram clearing pass
//   is needed
module pink_noise_voss_dice
  import pnvd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [WORD_W-1:0]          in_select_rand,
  input  logic [WORD_W-1:0]          in_white_rand,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_sample
);

  // handshake
  logic in_go;
  logic out_free;
  logic s1_go;

  // stage 1: die read in flight
  logic                 s1_v_r;
  logic [DIE_IDX_W-1:0] s1_k_r;
  logic [DIE_W-1:0]     s1_fresh_r;
  logic [DIE_W-1:0]     s1_white_r;

  // last die written, forwarded over the read-first ram
  logic                 lw_v_r;
  logic [DIE_IDX_W-1:0] lw_k_r;
  logic [DIE_W-1:0]     lw_d_r;

  // per-die valid bits stand in for a cleared ram
  logic [NUM_DICE-1:0]  dice_vld_r;

  logic [SUM_W-1:0]     sum_r;
  logic [SUM_W-1:0]     sum_nxt;

  logic                 out_v_r;
  logic [SAMPLE_W-1:0]  out_sample_r;
  logic [SAMPLE_W-1:0]  out_sample_nxt;

  logic [DIE_IDX_W-1:0] rd_k;
  logic [DIE_W-1:0]     ram_rd_data;
  logic [DIE_W-1:0]     old_die;

  // --------------------------------------------------------------------------
  // flow control: stage 1 moves on whenever the output register is free
  // --------------------------------------------------------------------------
  assign out_free = !out_v_r || !out_stall;
  assign s1_go    = s1_v_r && out_free;
  assign in_stall = s1_v_r && !out_free;
  assign in_go    = in_valid && !in_stall;

  assign rd_k = die_index(in_select_rand);

  // --------------------------------------------------------------------------
  // dice store
  // --------------------------------------------------------------------------
  pnvd_ram #(
    .WIDTH (DIE_W),
    .DEPTH (NUM_DICE)
  ) u_dice_ram (
    .clk     (clk),
    .wr_en   (s1_go),
    .wr_addr (s1_k_r),
    .wr_data (s1_fresh_r),
    .rd_en   (in_go),
    .rd_addr (rd_k),
    .rd_data (ram_rd_data)
  );

  // old die value: the last write wins (it may have raced the ram read),
  // else the ram word if the die was ever written, else zero
  always_comb begin
    if (lw_v_r && (lw_k_r == s1_k_r)) begin
      old_die = lw_d_r;
    end else if (dice_vld_r[s1_k_r]) begin
      old_die = ram_rd_data;
    end else begin
      old_die = '0;
    end
  end

  // running sum after swapping the die, then white part and centering offset
  always_comb begin
    sum_nxt        = sum_r + SUM_W'(s1_fresh_r) - SUM_W'(old_die);
    out_sample_nxt = SAMPLE_W'(sum_nxt) + SAMPLE_W'(s1_white_r) - HALF_SCALE;
  end

  // --------------------------------------------------------------------------
  // stage 1 registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_go) begin
      s1_v_r <= 1'b1;
    end else if (s1_go) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      s1_k_r     <= rd_k;
      s1_fresh_r <= in_select_rand[WORD_W-1:DIE_SHIFT];
      s1_white_r <= in_white_rand[WORD_W-1:DIE_SHIFT];
    end
  end

  // --------------------------------------------------------------------------
  // write-back side: sum, valid bits, forwarding register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r      <= '0;
      dice_vld_r <= '0;
      lw_v_r     <= 1'b0;
    end else if (s1_go) begin
      sum_r              <= sum_nxt;
      dice_vld_r[s1_k_r] <= 1'b1;
      lw_v_r             <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      lw_k_r <= s1_k_r;
      lw_d_r <= s1_fresh_r;
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_go) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_sample_r <= out_sample_nxt;
    end
  end

  assign out_valid  = out_v_r;
  assign out_sample = signed'(out_sample_r);

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // input is held back only while an item waits in stage 1
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_v_r)
    else $error("input stalled with stage 1 empty");

  // a new result only comes from a stage 1 transfer
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(s1_go))
    else $error("result appeared without stage 1 transfer");

  // die valid bits never drop once set
  a_vld_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (($past(dice_vld_r) & ~dice_vld_r) == '0))
    else $error("die valid bit cleared outside reset");

  // a write always leaves the written die marked valid
  a_vld_after_wr: assert property (@(posedge clk) disable iff (!rst_n)
    lw_v_r |-> dice_vld_r[lw_k_r])
    else $error("last written die not marked valid");

endmodule
